// ----- rtl/etd_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the elevation tile deframer.
// Used by every module in rtl; depends on nothing.
package etd_pkg;

  localparam int MAX_ROWS          = 4096;
  localparam int MAX_COLS          = 4096;
  localparam int HEADER_BYTES      = 3428;
  localparam int RECORD_LEAD_BYTES = 8;
  localparam int RECORD_TAIL_BYTES = 4;

  localparam int CNT_W  = 13;
  localparam int IDX_W  = 12;
  localparam int POS_W  = 14;
  localparam int HDR_W  = 12;
  localparam int VOID_W = 25;

  localparam logic [CNT_W-1:0] ROWS_RESET = 13'd3601;
  localparam logic [CNT_W-1:0] COLS_RESET = 13'd3601;

  localparam logic signed [15:0] VOID_VALUE = 16'sh8000;
  localparam logic signed [15:0] MIN_START  = 16'sh7fff;
  localparam logic signed [15:0] MAX_START  = 16'sh8001;
  localparam logic [VOID_W-1:0]  VOID_MAX   = {VOID_W{1'b1}};

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } byte_t;

  typedef struct packed {
    logic signed [15:0] elevation;
    logic [IDX_W-1:0]   column_index;
    logic [IDX_W-1:0]   row_index;
    logic               is_void;
    logic signed [15:0] elev_min;
    logic signed [15:0] elev_max;
    logic [VOID_W-1:0]  void_total;
    logic               last_post;
  } post_out_t;

  typedef struct packed {
    logic [15:0]      raw;
    logic [IDX_W-1:0] column;
    logic [IDX_W-1:0] row;
    logic             last;
    logic             fresh;
  } post_t;

  typedef struct packed {
    logic [CNT_W-1:0] rows;
    logic [CNT_W-1:0] cols;
  } cfg_t;

  function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] top);
    logic [CNT_W-1:0] r;
    r = v;
    if (v == '0) r = {{(CNT_W-1){1'b0}}, 1'b1};
    else if (v > top) r = top;
    return r;
  endfunction

endpackage

// ----- rtl/elevation_tile_deframer.sv -----
`timescale 1ns / 1ps
// Elevation tile deframer top level: register port, classifier, queue, stats.
// Depends on etd_pkg, etd_front, etd_queue, etd_back.
//
// Takes one raw tile-file byte per cycle with no gaps of its own: a byte is
// accepted every cycle while the two-entry post queue has room, so the
// sustained rate is one byte per clock. Header bytes, record lead and tail
// bytes produce nothing; every second data byte completes a post, which is
// written to a queue slot and then to the statistics output register, and
// comes out with its column, row, void flag, running min/max over
// non-void posts, saturating void count and a last-post mark. A byte with
// file_start set restarts the file. rows_per_column (address 0) and
// column_count (address 4) clamp to 1..4096 and may be changed only while
// the block is idle.
module elevation_tile_deframer (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  etd_pkg::byte_t     byte_item,
  output logic               post_valid,
  input  logic               post_stall,
  output etd_pkg::post_out_t post_item
);

  logic [etd_pkg::CNT_W-1:0] rows_per_column, column_count;
  etd_pkg::cfg_t             cfg;
  logic                      wr_en, accept, push, full, pop, q_valid;
  etd_pkg::post_t            f_post, q_post;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_per_column <= etd_pkg::ROWS_RESET;
      column_count    <= etd_pkg::COLS_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        etd_pkg::REG_ROWS: rows_per_column <= pwdata[etd_pkg::CNT_W-1:0];
        etd_pkg::REG_COLS: column_count    <= pwdata[etd_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      etd_pkg::REG_ROWS: prdata = {{(32-etd_pkg::CNT_W){1'b0}}, rows_per_column};
      etd_pkg::REG_COLS: prdata = {{(32-etd_pkg::CNT_W){1'b0}}, column_count};
      default:           prdata = '0;
    endcase
  end

  assign cfg.rows = etd_pkg::clamp_count(rows_per_column, etd_pkg::CNT_W'(etd_pkg::MAX_ROWS));
  assign cfg.cols = etd_pkg::clamp_count(column_count, etd_pkg::CNT_W'(etd_pkg::MAX_COLS));

  assign byte_stall = full;
  assign accept     = byte_valid && !byte_stall;

  etd_front u_front (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (byte_item),
    .cfg    (cfg),
    .push   (push),
    .post   (f_post)
  );

  etd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_post  (f_post),
    .full     (full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_post  (q_post)
  );

  etd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_post    (q_post),
    .pop       (pop),
    .out_valid (post_valid),
    .out_stall (post_stall),
    .out_post  (post_item)
  );

endmodule

// ----- rtl/etd_front.sv -----
`timescale 1ns / 1ps
// Byte classifier: header skip, record lead, post pairing, record tail.
// Pushes completed posts toward the queue; uses etd_pkg.
module etd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  etd_pkg::byte_t item,
  input  etd_pkg::cfg_t  cfg,
  output logic           push,
  output etd_pkg::post_t post
);

  logic [etd_pkg::HDR_W-1:0] header_left, header_left_next, hl_e;
  logic [etd_pkg::POS_W-1:0] record_position, record_position_next, pos_e, pos_inc;
  logic [etd_pkg::IDX_W-1:0] current_column, current_column_next, col_e;
  logic [7:0]                high_byte_hold, high_byte_hold_next, hold_e;
  logic                      tile_done, tile_done_next, done_e;
  logic                      fresh, fresh_next, fresh_e;
  logic [etd_pkg::POS_W-1:0] data_end, rec_end, off;
  logic                      is_data, col_last, row_last, push_c;
  logic [etd_pkg::IDX_W-1:0] row;

  always_comb begin
    hl_e    = item.file_start ? etd_pkg::HDR_W'(etd_pkg::HEADER_BYTES) : header_left;
    pos_e   = item.file_start ? '0 : record_position;
    col_e   = item.file_start ? '0 : current_column;
    hold_e  = item.file_start ? '0 : high_byte_hold;
    done_e  = item.file_start ? 1'b0 : tile_done;
    fresh_e = item.file_start ? 1'b1 : fresh;

    data_end = etd_pkg::POS_W'(etd_pkg::RECORD_LEAD_BYTES)
             + {cfg.rows, 1'b0};
    rec_end  = data_end + etd_pkg::POS_W'(etd_pkg::RECORD_TAIL_BYTES);
    off      = pos_e - etd_pkg::POS_W'(etd_pkg::RECORD_LEAD_BYTES);
    is_data  = (pos_e >= etd_pkg::POS_W'(etd_pkg::RECORD_LEAD_BYTES)) && (pos_e < data_end);
    row      = off[etd_pkg::IDX_W:1];
    col_last = ({1'b0, col_e} + 13'd1) >= cfg.cols;
    row_last = ({1'b0, row} + 13'd1) >= cfg.rows;
    pos_inc  = pos_e + 14'd1;

    header_left_next     = hl_e;
    record_position_next = pos_e;
    current_column_next  = col_e;
    high_byte_hold_next  = hold_e;
    tile_done_next       = done_e;
    fresh_next           = fresh_e;
    push_c               = 1'b0;

    if (!done_e) begin
      if (hl_e != '0) begin
        header_left_next = hl_e - 12'd1;
      end else begin
        if (is_data) begin
          if (!off[0]) begin
            high_byte_hold_next = item.data_byte;
          end else begin
            push_c     = 1'b1;
            fresh_next = 1'b0;
            if (col_last && row_last) tile_done_next = 1'b1;
          end
        end
        if (pos_inc >= rec_end) begin
          record_position_next = '0;
          if (col_last) tile_done_next = 1'b1;
          else current_column_next = col_e + 12'd1;
        end else begin
          record_position_next = pos_inc;
        end
      end
    end
  end

  assign push        = accept && push_c;
  assign post.raw    = {hold_e, item.data_byte};
  assign post.column = col_e;
  assign post.row    = row;
  assign post.last   = col_last && row_last;
  assign post.fresh  = fresh_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_left     <= etd_pkg::HDR_W'(etd_pkg::HEADER_BYTES);
      record_position <= '0;
      current_column  <= '0;
      high_byte_hold  <= '0;
      tile_done       <= 1'b0;
      fresh           <= 1'b1;
    end else if (accept) begin
      header_left     <= header_left_next;
      record_position <= record_position_next;
      current_column  <= current_column_next;
      high_byte_hold  <= high_byte_hold_next;
      tile_done       <= tile_done_next;
      fresh           <= fresh_next;
    end
  end

endmodule

// ----- rtl/etd_queue.sv -----
`timescale 1ns / 1ps
// Two-entry post queue between classifier and statistics stage.
// Uses etd_pkg for the post type.
module etd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  etd_pkg::post_t wr_post,
  output logic           full,
  input  logic           pop,
  output logic           rd_valid,
  output etd_pkg::post_t rd_post
);

  etd_pkg::post_t slots [2];
  logic           wr_ptr, rd_ptr;
  logic [1:0]     count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_post  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_post;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> (!full || pop))
    else $error("post queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> rd_valid)
    else $error("post queue underflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("post queue count out of range");

endmodule

// ----- rtl/etd_back.sv -----
`timescale 1ns / 1ps
// Statistics stage: void flag, running min/max, void count, output register.
// Uses etd_pkg.
module etd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  etd_pkg::post_t     q_post,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output etd_pkg::post_out_t out_post
);

  logic signed [15:0]         elev_min, elev_max, base_min, base_max, v;
  logic signed [15:0]         elev_min_next, elev_max_next;
  logic [etd_pkg::VOID_W-1:0] void_counter, void_counter_next, base_void;
  logic                       is_void;

  assign pop = q_valid && (!out_valid || !out_stall);

  always_comb begin
    v         = $signed(q_post.raw);
    is_void   = (v == etd_pkg::VOID_VALUE);
    base_min  = q_post.fresh ? etd_pkg::MIN_START : elev_min;
    base_max  = q_post.fresh ? etd_pkg::MAX_START : elev_max;
    base_void = q_post.fresh ? '0 : void_counter;
    elev_min_next     = base_min;
    elev_max_next     = base_max;
    void_counter_next = base_void;
    if (is_void) begin
      if (base_void != etd_pkg::VOID_MAX) void_counter_next = base_void + 25'd1;
    end else begin
      if (v < base_min) elev_min_next = v;
      if (v > base_max) elev_max_next = v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      elev_min     <= etd_pkg::MIN_START;
      elev_max     <= etd_pkg::MAX_START;
      void_counter <= '0;
    end else begin
      if (pop) begin
        out_valid    <= 1'b1;
        elev_min     <= elev_min_next;
        elev_max     <= elev_max_next;
        void_counter <= void_counter_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_post.elevation    <= v;
      out_post.column_index <= q_post.column;
      out_post.row_index    <= q_post.row;
      out_post.is_void      <= is_void;
      out_post.elev_min     <= elev_min_next;
      out_post.elev_max     <= elev_max_next;
      out_post.void_total   <= void_counter_next;
      out_post.last_post    <= q_post.last;
    end
  end

  a_stats_bracket: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_post.is_void) |->
      (out_post.elev_min <= out_post.elevation && out_post.elevation <= out_post.elev_max))
    else $error("non-void post outside running min/max");
  a_void_counts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_post.is_void) |-> out_post.void_total != '0)
    else $error("void post with zero void total");
  a_stats_track: assert property (@(posedge clk) disable iff (rst)
    $past(pop) |-> (out_post.void_total == void_counter && out_post.elev_min == elev_min))
    else $error("output statistics out of step with running state");

endmodule

// ----- tb/sv/etd_post_checker.sv -----
`timescale 1ns / 1ps
// Post checker for the elevation tile deframer: follows register writes and
// accepted bytes, predicts each post, compares accepted posts in order.
// Depends on etd_pkg for the request and post types and the format constants.
module etd_post_checker
  import etd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       psel,
  input  logic       penable,
  input  logic       pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  input  logic       pready,
  input  logic       byte_valid,
  input  logic       byte_stall,
  input  byte_t      byte_item,
  input  logic       post_valid,
  input  logic       post_stall,
  input  post_out_t  post_item,
  output int         mismatches,
  output int         pending
);

  logic [CNT_W-1:0]   rows_reg;
  logic [CNT_W-1:0]   cols_reg;
  int unsigned        header_left;
  int unsigned        rec_pos;
  int unsigned        col;
  int unsigned        row;
  logic [7:0]         hold_hi;
  logic signed [15:0] lowest;
  logic signed [15:0] highest;
  logic [VOID_W-1:0]  voids;
  bit                 tile_over;
  post_out_t          posts_due[$];

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic int unsigned span(input logic [CNT_W-1:0] w, input int unsigned top);
    if (w == '0) return 1;
    return (w > top) ? top : int'(w);
  endfunction

  function automatic void restart_file();
    header_left = HEADER_BYTES;
    rec_pos = 0;
    col = 0;
    row = 0;
    hold_hi = 8'h00;
    lowest = MIN_START;
    highest = MAX_START;
    voids = '0;
    tile_over = 1'b0;
  endfunction

  function automatic void deframe_byte(input byte_t b);
    int unsigned        rows;
    int unsigned        cols;
    int unsigned        data_end;
    int unsigned        rec_end;
    int unsigned        off;
    logic signed [15:0] v;
    bit                 last;
    post_out_t          p;
    if (b.file_start) restart_file();
    if (tile_over) return;
    if (header_left > 0) begin
      header_left--;
      return;
    end
    rows = span(rows_reg, MAX_ROWS);
    cols = span(cols_reg, MAX_COLS);
    data_end = RECORD_LEAD_BYTES + 2 * rows;
    rec_end = data_end + RECORD_TAIL_BYTES;
    if (rec_pos >= RECORD_LEAD_BYTES && rec_pos < data_end) begin
      off = rec_pos - RECORD_LEAD_BYTES;
      row = off >> 1;
      if (off % 2 == 0) begin
        hold_hi = b.data_byte;
      end else begin
        v = {hold_hi, b.data_byte};
        last = (col + 1 >= cols) && (row + 1 >= rows);
        if (v == VOID_VALUE) begin
          if (voids != VOID_MAX) voids++;
        end else begin
          if (v < lowest) lowest = v;
          if (v > highest) highest = v;
        end
        p.elevation = v;
        p.column_index = IDX_W'(col);
        p.row_index = IDX_W'(row);
        p.is_void = (v == VOID_VALUE);
        p.elev_min = lowest;
        p.elev_max = highest;
        p.void_total = voids;
        p.last_post = last;
        posts_due.push_back(p);
        if (last) tile_over = 1'b1;
      end
    end
    rec_pos++;
    if (rec_pos >= rec_end) begin
      rec_pos = 0;
      row = 0;
      if (col + 1 >= cols) tile_over = 1'b1;
      else col++;
    end
  endfunction

  function automatic void flag_field(input string field, input longint unsigned want,
                                     input longint unsigned got);
    $display("%0t ns: post %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    mismatches++;
  endfunction

  always @(posedge clk) begin
    post_out_t want;
    if (rst) begin
      rows_reg = ROWS_RESET;
      cols_reg = COLS_RESET;
      restart_file();
      posts_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COLS) cols_reg = pwdata[CNT_W-1:0];
        else rows_reg = pwdata[CNT_W-1:0];
      end
      if (post_valid && !post_stall) begin
        if (posts_due.size() == 0) begin
          $display("%0t ns: unexpected post, expected none, actual %h", $time, post_item);
          mismatches++;
        end else begin
          want = posts_due.pop_front();
          if (post_item.elevation !== want.elevation)
            flag_field("elevation", 16'(want.elevation), 16'(post_item.elevation));
          if (post_item.column_index !== want.column_index)
            flag_field("column_index", want.column_index, post_item.column_index);
          if (post_item.row_index !== want.row_index)
            flag_field("row_index", want.row_index, post_item.row_index);
          if (post_item.is_void !== want.is_void)
            flag_field("is_void", want.is_void, post_item.is_void);
          if (post_item.elev_min !== want.elev_min)
            flag_field("elev_min", 16'(want.elev_min), 16'(post_item.elev_min));
          if (post_item.elev_max !== want.elev_max)
            flag_field("elev_max", 16'(want.elev_max), 16'(post_item.elev_max));
          if (post_item.void_total !== want.void_total)
            flag_field("void_total", want.void_total, post_item.void_total);
          if (post_item.last_post !== want.last_post)
            flag_field("last_post", want.last_post, post_item.last_post);
        end
      end
      if (byte_valid && !byte_stall) deframe_byte(byte_item);
    end
    pending = posts_due.size();
  end

endmodule

// ----- tb/sv/tb_elevation_tile_deframer.sv -----
`timescale 1ns / 1ps
// Top of the elevation tile deframer bench: clock, reset, register writes,
// tile byte streams and receiver stalls; the verdict comes from etd_post_checker.
// Depends on etd_pkg, elevation_tile_deframer and etd_post_checker.
module tb_elevation_tile_deframer;
  import etd_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_PAD   = 8;
  localparam int LIMIT       = 1500000;
  localparam int BODY_QUOTA  = 320;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        byte_valid = 1'b0;
  logic        byte_stall;
  byte_t       byte_item = '0;
  logic        post_valid;
  logic        post_stall = 1'b0;
  post_out_t   post_item;
  int          mismatches;
  int          pending;

  int          send_idle = 12;
  int          rcv_idle = 51;
  int          hold_left = 0;
  int          body_sent = 0;
  int          cycles = 0;
  logic [15:0] fixed_posts[$];

  elevation_tile_deframer DUT (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .post_valid (post_valid),
    .post_stall (post_stall),
    .post_item  (post_item)
  );

  etd_post_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .post_valid (post_valid),
    .post_stall (post_stall),
    .post_item  (post_item),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("tb_elevation_tile_deframer: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      post_stall <= 1'b0;
    end else if (hold_left > 0) begin
      post_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      post_stall <= ($urandom_range(99) < rcv_idle);
    end
  end

  task automatic send_byte(input byte_t b);
    while ($urandom_range(99) < send_idle) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item <= b;
    do @(posedge clk); while (byte_stall);
    @(negedge clk);
  endtask

  task automatic send_noise(input int count);
    byte_t b;
    b.file_start = 1'b0;
    repeat (count) begin
      b.data_byte = 8'($urandom_range(255));
      send_byte(b);
    end
  endtask

  task automatic settle();
    byte_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_PAD) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input int unsigned val);
    logic [31:0] w;
    w = $urandom;
    w[CNT_W-1:0] = val[CNT_W-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= w;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_dims(input int unsigned rows_w, input int unsigned cols_w);
    settle();
    write_reg(REG_ROWS, rows_w);
    write_reg(REG_COLS, cols_w);
  endtask

  // rows and cols are the clamped shape; cut > 0 truncates the stream
  task automatic send_tile(input int rows, input int cols, input int void_pct,
                           input int trailing, input int cut, input bit hold);
    byte_t       seq[$];
    byte_t       b;
    logic [15:0] post;
    int          body_end;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b.data_byte = 8'($urandom_range(255));
      b.file_start = (i == 0);
      seq.push_back(b);
    end
    b.file_start = 1'b0;
    for (int c = 0; c < cols; c++) begin
      repeat (RECORD_LEAD_BYTES) begin
        b.data_byte = 8'($urandom_range(255));
        seq.push_back(b);
      end
      for (int r = 0; r < rows; r++) begin
        if (fixed_posts.size() > 0) begin
          post = fixed_posts.pop_front();
        end else if ($urandom_range(99) < void_pct) begin
          post = VOID_VALUE;
        end else if ($urandom_range(7) == 0) begin
          case ($urandom_range(3))
            0: post = 16'h7fff;
            1: post = 16'h8001;
            2: post = 16'h0000;
            default: post = 16'hffff;
          endcase
        end else begin
          post = 16'($urandom_range(16'hffff));
        end
        b.data_byte = post[15:8];
        seq.push_back(b);
        b.data_byte = post[7:0];
        seq.push_back(b);
      end
      repeat (RECORD_TAIL_BYTES) begin
        b.data_byte = 8'($urandom_range(255));
        seq.push_back(b);
      end
    end
    body_end = seq.size();
    repeat (trailing) begin
      b.data_byte = 8'($urandom_range(255));
      seq.push_back(b);
    end
    if (cut > 0) while (seq.size() > cut) void'(seq.pop_back());
    foreach (seq[i]) begin
      if (hold && i == HEADER_BYTES) hold_left = HOLD_CYCLES;
      if (i >= HEADER_BYTES && i < body_end) body_sent++;
      send_byte(seq[i]);
    end
  endtask

  initial begin
    int unsigned rows_w;
    int unsigned cols_w;
    int          rows;
    int          cols;
    int          void_pct;
    int          cut;
    int          target;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_dims(2, 2);
    fixed_posts = '{16'h7fff, 16'h8000, 16'h8001, 16'h0000};
    send_tile(2, 2, 0, 3, 0, 1'b0);

    set_dims(0, 0);
    fixed_posts = '{16'h8000};
    send_tile(1, 1, 0, 2, 0, 1'b0);

    set_dims(8191, 1);
    send_tile(MAX_ROWS, 1, 10, 0, 0, 1'b1);

    set_dims(1, 8191);
    send_tile(1, 6, 30, 0, HEADER_BYTES + 70, 1'b0);

    // shrink rows, then columns, in the middle of a tile
    set_dims(4, 3);
    send_tile(4, 3, 20, 0, HEADER_BYTES + 32, 1'b0);
    settle();
    write_reg(REG_ROWS, 1);
    send_noise(4);
    settle();
    write_reg(REG_COLS, 2);
    send_noise(20);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 12 : (ph == 1) ? 51 : 0;
      rcv_idle = (ph == 0) ? 51 : (ph == 1) ? 12 : 0;
      target = body_sent + BODY_QUOTA;
      while (body_sent < target) begin
        case ($urandom_range(9))
          0: rows_w = 0;
          1: rows_w = $urandom_range(48, 17);
          default: rows_w = $urandom_range(8, 1);
        endcase
        cols_w = ($urandom_range(4) == 0) ? 0 : $urandom_range(5, 1);
        rows = (rows_w == 0) ? 1 : rows_w;
        cols = (cols_w == 0) ? 1 : cols_w;
        case ($urandom_range(2))
          0: void_pct = 0;
          1: void_pct = 20;
          default: void_pct = 100;
        endcase
        cut = 0;
        if ($urandom_range(7) == 0)
          cut = $urandom_range(HEADER_BYTES + cols * (RECORD_LEAD_BYTES +
                               RECORD_TAIL_BYTES + 2 * rows) - 1, 1);
        set_dims(rows_w, cols_w);
        send_tile(rows, cols, void_pct, $urandom_range(4), cut, 1'b0);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_elevation_tile_deframer: clean");
    end else begin
      $display("tb_elevation_tile_deframer: errors");
    end
    $finish;
  end

endmodule
